FILE: src/rc5_ir_edge_decoder_defines.svh
// Assertion macros used by the RC5 edge decoder top level.
`ifndef RC5_IR_EDGE_DECODER_DEFINES_SVH
`define RC5_IR_EDGE_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RC5IR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rc5 decoder check failed");

// Next-cycle implication, checked out of reset.
`define RC5IR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rc5 decoder check failed");

`endif

FILE: src/rc5ir_pkg.sv
// Types and constants shared by the RC5 edge decoder modules.
package rc5ir_pkg;

  // Half-bit phase beyond which a frame is complete
  localparam logic [4:0] FRAME_HALF_BITS = 5'd26;

  // Phase value while waiting for the start edge
  localparam logic [4:0] PHASE_IDLE  = 5'd1;
  localparam logic [4:0] PHASE_RESYN = 5'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_HALF_BIT  = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_LAST_BIT  = 2'd2;

  // Register reset values
  localparam logic [12:0] HALF_BIT_RST  = 13'd889;
  localparam logic [11:0] TOLERANCE_RST = 12'd200;
  localparam logic [4:0]  LAST_BIT_RST  = 5'd26;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_BUSY  = 3'd1,
    ST_LONG  = 3'd2,
    ST_SHORT = 3'd3,
    ST_PHASE = 3'd4
  } rc5ir_status_e;

  typedef struct packed {
    logic [12:0] half_bit;
    logic [11:0] tolerance;
    logic [4:0]  last_bit;
  } rc5ir_cfg_t;

  // One classified edge: kind and time since the previous edge
  typedef struct packed {
    logic        rising;
    logic [15:0] dur;
  } rc5ir_edge_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rc5ir_q_status_t;

endpackage

FILE: src/rc5_ir_edge_decoder.sv
// Top level of the RC5 infrared edge decoder.
// Decodes Manchester-coded RC5 frames from timestamped receiver edges, one
// result transfer for every edge transfer. Throughput is one edge per clock
// cycle while the edge queue is not full and results are taken. An edge is
// written into the edge queue at the edge of its transfer. Once it is at the
// queue head and the result register is empty or being taken, the back end
// decodes it straight from the queue head with combinational window compares
// and phase update, and the result register loads it. The result is offered
// from the result register. The edge queue of QUEUE_DEPTH entries lets input
// and output stall independently. When the queue is full the input is held
// off for that cycle, even if the back end takes an entry in the same cycle.
// Registers: half-bit length at 0x0, tolerance at 0x4, last-bit phase at 0x8;
// write them only while no edge is in flight.
`include "rc5_ir_edge_decoder_defines.svh"

module rc5_ir_edge_decoder
  import rc5ir_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)(
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Edge input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] timestamp
  input  logic        s_axis_tuser,   // [0] rising edge
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [4:0] phase, [20:5] code_word, [23:21] zero
  output logic [2:0]  m_axis_tuser    // [2:0] status
);

  rc5ir_cfg_t      cfg;
  rc5ir_q_status_t q_status;
  rc5ir_edge_t     push_data, pop_data;
  rc5ir_status_e   status;
  logic            push, pop;
  logic [4:0]      phase;
  logic [15:0]     code_word;

  rc5ir_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rc5ir_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_rising_i (s_axis_tuser),
    .in_time_i   (s_axis_tdata),
    .q_full_i    (q_status.full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rc5ir_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  rc5ir_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_empty_i    (q_status.empty),
    .q_data_i     (pop_data),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (status),
    .out_phase_o  (phase),
    .out_word_o   (code_word)
  );

  assign m_axis_tdata = {3'd0, code_word, phase};
  assign m_axis_tuser = status;

  // A pushed edge is waiting in the queue on the next cycle
  `RC5IR_ASSERT_NEXT(a_push_fills, push && !pop, !q_status.empty)
  // The back end never takes from an empty queue
  `RC5IR_ASSERT_NOW(a_pop_nonempty, pop, !q_status.empty)
  // A completed frame leaves the decoder idle
  `RC5IR_ASSERT_NOW(a_done_idle, m_axis_tvalid && (status == ST_DONE), phase == PHASE_IDLE)
  // Timing errors resynchronise or return to idle
  `RC5IR_ASSERT_NOW(a_err_phase,
    m_axis_tvalid && (status == ST_LONG || status == ST_SHORT),
    phase == PHASE_RESYN || phase == PHASE_IDLE)

endmodule

FILE: src/rc5ir_cfg.sv
// APB register file holding the decoder timing configuration.
module rc5ir_cfg
  import rc5ir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output rc5ir_cfg_t  cfg_o
);

  rc5ir_cfg_t cfg_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit  <= HALF_BIT_RST;
      cfg_q.tolerance <= TOLERANCE_RST;
      cfg_q.last_bit  <= LAST_BIT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HALF_BIT:  cfg_q.half_bit  <= pwdata[12:0];
        REG_TOLERANCE: cfg_q.tolerance <= pwdata[11:0];
        REG_LAST_BIT:  cfg_q.last_bit  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    case (paddr[3:2])
      REG_HALF_BIT:  prdata = {19'd0, cfg_q.half_bit};
      REG_TOLERANCE: prdata = {20'd0, cfg_q.tolerance};
      REG_LAST_BIT:  prdata = {27'd0, cfg_q.last_bit};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/rc5ir_front.sv
// Front end: takes edge transfers and turns timestamps into durations.
module rc5ir_front
  import rc5ir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_rising_i,
  input  logic [15:0] in_time_i,
  input  logic        q_full_i,
  output logic        in_ready_o,
  output logic        push_o,
  output rc5ir_edge_t push_data_o
);

  logic [15:0] last_time_q;

  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Duration modulo 2^16 since the previous edge
  assign push_data_o.rising = in_rising_i;
  assign push_data_o.dur    = in_time_i - last_time_q;

  // Every accepted edge becomes the new reference time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= 16'd0;
    end else if (push_o) begin
      last_time_q <= in_time_i;
    end
  end

endmodule

FILE: src/rc5ir_queue.sv
// Small FIFO of classified edges between the front and back ends.
module rc5ir_queue
  import rc5ir_pkg::*;
#(
  parameter int DEPTH = 2  // at least 2
)(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rc5ir_edge_t     push_data_i,
  input  logic            pop_i,
  output rc5ir_edge_t     pop_data_o,
  output rc5ir_q_status_t status_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rc5ir_edge_t      slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = slot_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: src/rc5ir_back.sv
// Back end: window compares, phase and shift word update, result register.
module rc5ir_back
  import rc5ir_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rc5ir_cfg_t    cfg_i,
  input  logic          q_empty_i,
  input  rc5ir_edge_t   q_data_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rc5ir_status_e out_status_o,
  output logic [4:0]    out_phase_o,
  output logic [15:0]   out_word_o
);

  logic [4:0]    phase_q, phase_d;
  logic [15:0]   shift_q, shift_d;
  logic          out_valid_q;
  rc5ir_status_e status_q, status_d;

  logic signed [18:0] d, h, t;
  logic signed [18:0] h2, h3, h5, h7;
  logic signed [18:0] lim_l1, lim_l3, lim_l4, lim_s1, lim_s2;
  logic signed [18:0] mid3, mid5, mid7;
  logic [5:0]         p_add;

  assign pop_o = ~q_empty_i & (~out_valid_q | out_ready_i);

  // Window limits from the half-bit length and tolerance
  assign d      = signed'({3'd0, q_data_i.dur});
  assign h      = signed'({6'd0, cfg_i.half_bit});
  assign t      = signed'({7'd0, cfg_i.tolerance});
  assign h2     = h <<< 1;
  assign h3     = h2 + h;
  assign h5     = (h <<< 2) + h;
  assign h7     = (h <<< 3) - h;
  assign lim_l1 = h2 + t;
  assign lim_l3 = h3 + t;
  assign lim_l4 = (h <<< 2) + t;
  assign lim_s1 = h - t;
  assign lim_s2 = h2 - t;
  assign mid3   = h3 >>> 1;
  assign mid5   = h5 >>> 1;
  assign mid7   = h7 >>> 1;

  // Decode one edge against the current phase
  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    status_d = ST_BUSY;
    p_add    = {1'b0, phase_q};
    if (q_data_i.rising) begin
      if (phase_q != cfg_i.last_bit) begin
        status_d = ST_PHASE;
      end else begin
        phase_d = PHASE_IDLE;
        if (d > lim_l1) begin
          status_d = ST_LONG;
        end else if (d < lim_s1) begin
          status_d = ST_SHORT;
        end else begin
          shift_d  = {shift_q[14:0], (d > mid3)};
          status_d = ST_DONE;
        end
      end
    end else if (phase_q == PHASE_IDLE) begin
      phase_d = PHASE_RESYN;
    end else begin
      if (phase_q[0]) begin
        if (d > lim_l3) begin
          status_d = ST_LONG;
        end else if (d < lim_s2) begin
          status_d = ST_SHORT;
        end else if (d > mid5) begin
          shift_d = {shift_q[14:0], 1'b1};
          p_add   = {1'b0, phase_q} + 6'd3;
        end else begin
          shift_d = {shift_q[14:0], 1'b0};
          p_add   = {1'b0, phase_q} + 6'd2;
        end
      end else begin
        if (d > lim_l4) begin
          status_d = ST_LONG;
        end else if (d < lim_s2) begin
          status_d = ST_SHORT;
        end else if (d > mid5) begin
          if (d > mid7) begin
            shift_d = {shift_q[13:0], 2'b01};
            p_add   = {1'b0, phase_q} + 6'd4;
          end else begin
            shift_d = {shift_q[13:0], 2'b00};
            p_add   = {1'b0, phase_q} + 6'd3;
          end
        end else begin
          shift_d = {shift_q[14:0], 1'b1};
          p_add   = {1'b0, phase_q} + 6'd2;
        end
      end
      // Errors resynchronise; otherwise check for frame end
      if (status_d == ST_LONG || status_d == ST_SHORT) begin
        phase_d = PHASE_RESYN;
      end else if (p_add > {1'b0, FRAME_HALF_BITS}) begin
        phase_d  = PHASE_IDLE;
        status_d = ST_DONE;
      end else begin
        phase_d = p_add[4:0];
      end
    end
  end

  // Hold decoder state and the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PHASE_IDLE;
      shift_q     <= 16'd0;
      out_valid_q <= 1'b0;
      status_q    <= ST_BUSY;
    end else if (pop_o) begin
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      status_q    <= status_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_phase_o  = phase_q;
  assign out_word_o   = shift_q;

endmodule
